>>> sv/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared constants and types for the SVPWM duty calculator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // The configuration register index is two bits wide.
  localparam int CFG_IDX_W = 2;

  // Q1.15 constants.
  localparam logic [14:0] SQRT3_2_Q15 = 15'd28378;
  localparam int          DUTY_W      = 16;
  localparam int          TRIG_W      = 15;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE  = 2'd0,
    REG_MAX_PULSE  = 2'd1,
    REG_OVM_ENABLE = 2'd2,
    REG_OVM_LIMIT  = 2'd3
  } cfg_idx_e;

endpackage

>>> sv/svpwm_div_pipe.sv
// ----------------------------------------------------------------------------
// svpwm_div_pipe
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one divisor, with a sideband that travels with the data.
// ----------------------------------------------------------------------------
module svpwm_div_pipe #(
  parameter int LANES = 3,
  parameter int N_W   = 32,
  parameter int D_W   = 16,
  parameter int Q_W   = 16,
  parameter int S_W   = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [LANES-1:0][N_W-1:0]       dividend_i,
  input  logic [D_W-1:0]                  divisor_i,
  input  logic [S_W-1:0]                  side_i,
  output logic                            valid_o,
  output logic [LANES-1:0][Q_W-1:0]       quot_o,
  output logic [LANES-1:0]                ovf_o,
  output logic [S_W-1:0]                  side_o
);

  localparam int CW = ((N_W > D_W + Q_W) ? N_W : D_W + Q_W) + 1;

  logic [Q_W-1:0]                         vld_q;
  logic [Q_W-1:0][D_W-1:0]                den_q;
  logic [Q_W-1:0][S_W-1:0]                side_q;
  logic [Q_W-1:0][LANES-1:0][N_W-1:0]     rem_q;
  logic [Q_W-1:0][LANES-1:0][Q_W-1:0]     quo_q;
  logic [Q_W-1:0][LANES-1:0]              ovf_q;

  // Valid bits move one stage per enabled cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int SH = Q_W - 1 - s;
    logic [D_W-1:0]                den_in;
    logic [S_W-1:0]                side_in;
    logic [LANES-1:0][N_W-1:0]     rem_in;
    logic [LANES-1:0][N_W-1:0]     rem_d;
    logic [LANES-1:0][Q_W-1:0]     quo_in;
    logic [LANES-1:0][Q_W-1:0]     quo_d;
    logic [LANES-1:0]              ovf_in;

    if (s == 0) begin : g_first
      // The quotient overflows when the dividend reaches divisor * 2^Q_W.
      always_comb begin
        den_in  = divisor_i;
        side_in = side_i;
        rem_in  = dividend_i;
        quo_in  = '0;
        for (int l = 0; l < LANES; l++) begin
          ovf_in[l] = CW'(dividend_i[l]) >= (CW'(divisor_i) << Q_W);
        end
      end
    end else begin : g_next
      always_comb begin
        den_in  = den_q[s-1];
        side_in = side_q[s-1];
        rem_in  = rem_q[s-1];
        quo_in  = quo_q[s-1];
        ovf_in  = ovf_q[s-1];
      end
    end

    // Trial subtraction of the shifted divisor for this quotient bit.
    always_comb begin
      logic [CW-1:0] trial;
      logic          ge;
      trial = CW'(den_in) << SH;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < LANES; l++) begin
        ge = CW'(rem_in[l]) >= trial;
        if (ge) begin
          rem_d[l] = rem_in[l] - N_W'(trial);
        end
        quo_d[l][SH] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        ovf_q[s]  <= ovf_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = quo_q[Q_W-1];
  assign ovf_o   = ovf_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

>>> sv/svpwm_duty_calculator.sv
// ----------------------------------------------------------------------------
// svpwm_duty_calculator
// Min-max zero-sequence SVPWM duty computation in fixed point, with duty
// clamping, optional overmodulation rescaling and ADC trigger points.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//  in        in         in_valid_i / in_ready_o   v_alpha_i, v_beta_i, dc_bus_i
//  out       out        out_valid_o / out_ready_i duty_a/b/c_o, trig_u/v_o,
//                                                 ovm_applied_o, bus_fault_o
//
// One item enters per cycle while the output does not stall. The pipeline is
// 4 front stages, 17 stages of the per-phase bus divider, 3 clamp/scale
// stages, 16 stages of the overmodulation divider and the output register.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output holds every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module svpwm_duty_calculator #(
  parameter int VOLT_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [svpwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [svpwm_pkg::DUTY_W-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [VOLT_WIDTH-1:0]       v_alpha_i,
  input  logic signed [VOLT_WIDTH-1:0]       v_beta_i,
  input  logic [VOLT_WIDTH-1:0]              dc_bus_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_a_o,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_b_o,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_c_o,
  output logic [svpwm_pkg::TRIG_W-1:0]       trig_u_o,
  output logic [svpwm_pkg::TRIG_W-1:0]       trig_v_o,
  output logic                               ovm_applied_o,
  output logic                               bus_fault_o
);
  import svpwm_pkg::*;

  localparam int W  = VOLT_WIDTH;
  localparam int NW = W + 16;
  localparam int YW = W + 19;
  localparam int DW = W + 1;
  localparam int QP = 17;
  localparam int PW = 2 * DUTY_W;

  // Configuration registers.
  logic [DUTY_W-1:0] min_q, max_q, lim_q;
  logic              ovm_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '0;
      max_q    <= DUTY_W'(32768);
      ovm_en_q <= 1'b0;
      lim_q    <= DUTY_W'(32768);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MIN_PULSE:  min_q    <= cfg_wdata_i;
        REG_MAX_PULSE:  max_q    <= cfg_wdata_i;
        REG_OVM_ENABLE: ovm_en_q <= cfg_wdata_i[0];
        REG_OVM_LIMIT:  lim_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output holds an untaken result.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: beta times sqrt(3)/2.
  logic                 v1_q;
  logic signed [W-1:0]  alpha1_q;
  logic signed [NW-1:0] bprod1_q;
  logic [W-1:0]         vdc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha1_q <= v_alpha_i;
      bprod1_q <= NW'(v_beta_i) * NW'($signed({1'b0, SQRT3_2_Q15}));
      vdc1_q   <= dc_bus_i;
    end
  end

  // Stage 2: inverse Clarke, phase voltages scaled by 32768.
  logic                       v2_q;
  logic signed [2:0][NW-1:0]  n2_q;
  logic [W-1:0]               vdc2_q;
  logic signed [NW-1:0]       a_full, a_half;

  assign a_full = NW'($signed({alpha1_q, 15'b0}));
  assign a_half = NW'($signed({alpha1_q, 14'b0}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q[0] <= a_full;
      n2_q[1] <= bprod1_q - a_half;
      n2_q[2] <= -a_half - bprod1_q;
      vdc2_q  <= vdc1_q;
    end
  end

  // Stage 3: smallest and largest phase voltage.
  logic                       v3_q;
  logic signed [2:0][NW-1:0]  n3_q;
  logic signed [NW-1:0]       nmin3_q, nmax3_q, nmin, nmax;
  logic [W-1:0]               vdc3_q;

  always_comb begin
    nmin = n2_q[0];
    nmax = n2_q[0];
    for (int i = 1; i < 3; i++) begin
      if ($signed(n2_q[i]) < $signed(nmin)) nmin = n2_q[i];
      if ($signed(n2_q[i]) > $signed(nmax)) nmax = n2_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_q    <= n2_q;
      nmin3_q <= nmin;
      nmax3_q <= nmax;
      vdc3_q  <= vdc2_q;
    end
  end

  // Stage 4: dividend 2n - nmin - nmax + 32769*vdc, so the quotient by
  // 2*vdc is the unclamped duty itself. A negative dividend lies below any
  // minimum pulse.
  logic                       v4_q;
  logic [2:0][YW-2:0]         dvd4_q;
  logic [2:0]                 neg4_q;
  logic [DW-1:0]              den4_q;
  logic                       fault4_q;
  logic signed [2:0][YW-1:0]  y4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y4[i] = (YW'($signed(n3_q[i])) <<< 1) - YW'(nmin3_q) - YW'(nmax3_q)
            + $signed(YW'({vdc3_q, 15'b0})) + $signed(YW'(vdc3_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg4_q[i] <= y4[i][YW-1];
        dvd4_q[i] <= y4[i][YW-1] ? '0 : y4[i][YW-2:0];
      end
      den4_q   <= {vdc3_q, 1'b0};
      fault4_q <= (vdc3_q == '0);
    end
  end

  // Per-phase division by twice the bus voltage.
  logic                 pv;
  logic [2:0][QP-1:0]   pq;
  logic [2:0]           povf;
  logic [3:0]           pside;

  svpwm_div_pipe #(
    .LANES(3), .N_W(YW - 1), .D_W(DW), .Q_W(QP), .S_W(4)
  ) u_phase_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v4_q),
    .dividend_i (dvd4_q),
    .divisor_i  (den4_q),
    .side_i     ({fault4_q, neg4_q}),
    .valid_o    (pv),
    .quot_o     (pq),
    .ovf_o      (povf),
    .side_o     (pside)
  );

  // Stage 5: clamp, lower bound first and then upper bound.
  logic                     v5_q;
  logic [2:0][DUTY_W-1:0]   d5_q;
  logic [2:0][DUTY_W-1:0]   d5;
  logic                     fault5_q;

  always_comb begin
    logic [QP-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = povf[i] ? '1 : pq[i];
      if (pside[3] || pside[i] || t < QP'(min_q)) t = QP'(min_q);
      if (t > QP'(max_q)) t = QP'(max_q);
      d5[i] = t[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= pv;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d5_q     <= d5;
      fault5_q <= pside[3];
    end
  end

  // Stage 6: largest duty and the overmodulation decision.
  logic                     v6_q;
  logic [2:0][DUTY_W-1:0]   d6_q;
  logic [DUTY_W-1:0]        m6_q, m5;
  logic                     app6_q, fault6_q, over5;

  always_comb begin
    m5    = d5_q[0];
    over5 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (d5_q[i] > m5) m5 = d5_q[i];
      if (d5_q[i] > lim_q) over5 = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d6_q     <= d5_q;
      m6_q     <= m5;
      app6_q   <= over5 && ovm_en_q && !fault5_q;
      fault6_q <= fault5_q;
    end
  end

  // Stage 7: duty times limit.
  logic                     v7_q;
  logic [2:0][DUTY_W-1:0]   d7_q;
  logic [2:0][PW-1:0]       prod7_q;
  logic [2:0][PW-1:0]       dvd7;
  logic [DUTY_W-1:0]        m7_q;
  logic                     app7_q, fault7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod7_q[i] <= PW'(d6_q[i]) * PW'(lim_q);
      end
      d7_q     <= d6_q;
      m7_q     <= m6_q;
      app7_q   <= app6_q;
      fault7_q <= fault6_q;
    end
  end

  // Round half up: add half of the largest duty before dividing.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd7[i] = prod7_q[i] + PW'(m7_q >> 1);
    end
  end

  // Overmodulation division by the largest duty.
  logic                     ov;
  logic [2:0][DUTY_W-1:0]   oq;
  logic [2:0]               oovf;
  logic [3*DUTY_W+1:0]      oside;
  logic [2:0][DUTY_W-1:0]   od;
  logic                     oapp, ofault;

  svpwm_div_pipe #(
    .LANES(3), .N_W(PW), .D_W(DUTY_W), .Q_W(DUTY_W), .S_W(3 * DUTY_W + 2)
  ) u_ovm_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v7_q),
    .dividend_i (dvd7),
    .divisor_i  (m7_q),
    .side_i     ({app7_q, fault7_q, d7_q}),
    .valid_o    (ov),
    .quot_o     (oq),
    .ovf_o      (oovf),
    .side_o     (oside)
  );

  assign oapp   = oside[3*DUTY_W+1];
  assign ofault = oside[3*DUTY_W];
  assign od     = oside[3*DUTY_W-1:0];

  // Output register.
  logic [2:0][DUTY_W-1:0] duty_q;
  logic [TRIG_W-1:0]      trig_u_q, trig_v_q;
  logic                   app_q, fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= ov;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        duty_q[i] <= oapp ? oq[i] : od[i];
      end
      trig_u_q <= od[0][DUTY_W-1:1];
      trig_v_q <= od[1][DUTY_W-1:1];
      app_q    <= oapp;
      fault_q  <= ofault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_a_o      = duty_q[0];
  assign duty_b_o      = duty_q[1];
  assign duty_c_o      = duty_q[2];
  assign trig_u_o      = trig_u_q;
  assign trig_v_o      = trig_v_q;
  assign ovm_applied_o = app_q;
  assign bus_fault_o   = fault_q;

  // A bus fault never comes with overmodulation.
  a_fault_no_ovm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bus_fault_o |-> !ovm_applied_o)
    else $error("bus fault reported with overmodulation applied");

  // Scaled duties never exceed the limit.
  a_ovm_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ovm_applied_o |->
      duty_a_o <= lim_q && duty_b_o <= lim_q && duty_c_o <= lim_q)
    else $error("overmodulated duty above limit");

  // Without scaling, the triggers are half of the delivered A and B duties.
  a_trig_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ovm_applied_o |->
      trig_u_o == duty_a_o[DUTY_W-1:1] && trig_v_o == duty_b_o[DUTY_W-1:1])
    else $error("trigger point does not match duty");

  // The scaling quotient always fits in a duty.
  a_ovm_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov && oapp |-> oovf == 3'b000)
    else $error("overmodulation quotient overflow");

endmodule

>>> verif/svpwm_duty_calculator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svpwm_duty_calculator_test
// Checks the SVPWM duty calculator against a fixed-point predictor. A short
// table of directed items runs first, then random items under several
// clamp and overmodulation settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module svpwm_duty_calculator_test;
  import svpwm_pkg::*;

  localparam int VW          = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;
  localparam int RAND_PER_PH = 66;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [TRIG_W-1:0] trig_u;
    logic [TRIG_W-1:0] trig_v;
    logic              ovm_applied;
    logic              bus_fault;
  } duty_set_t;

  typedef struct {
    logic signed [VW-1:0] alpha;
    logic signed [VW-1:0] beta;
    logic [VW-1:0]        bus;
    bit                   typed;
    duty_set_t            result;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = REG_MIN_PULSE;
  logic [DUTY_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VW-1:0] v_alpha = '0;
  logic signed [VW-1:0] v_beta = '0;
  logic [VW-1:0] dc_bus = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wire duty_set_t dut_out;

  // Register copies used by the predictor.
  int unsigned pulse_lo, pulse_hi, ovm_on, ovm_lim;

  duty_set_t expected_duties[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_faults = 0;
  int rdy_wait = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  svpwm_duty_calculator #(.VOLT_WIDTH(VW)) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .v_alpha_i     (v_alpha),
    .v_beta_i      (v_beta),
    .dc_bus_i      (dc_bus),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .duty_a_o      (dut_out.duty_a),
    .duty_b_o      (dut_out.duty_b),
    .duty_c_o      (dut_out.duty_c),
    .trig_u_o      (dut_out.trig_u),
    .trig_v_o      (dut_out.trig_v),
    .ovm_applied_o (dut_out.ovm_applied),
    .bus_fault_o   (dut_out.bus_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor division for a positive divisor.
  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_pulse(longint t);
    if (t < longint'(pulse_lo)) t = pulse_lo;
    if (t > longint'(pulse_hi)) t = pulse_hi;
    return t;
  endfunction

  // Duties from an alpha/beta command under the current register settings.
  function automatic duty_set_t predict_duties(logic signed [VW-1:0] alpha,
                                               logic signed [VW-1:0] beta,
                                               logic [VW-1:0] bus);
    duty_set_t r;
    longint a, b, vdc, nmin, nmax, lim, m;
    longint n[3];
    longint d[3];
    a = alpha;
    b = beta;
    vdc = bus;
    r = '0;
    if (vdc == 0) begin
      r.bus_fault = 1'b1;
      for (int i = 0; i < 3; i++) d[i] = clamp_pulse(pulse_lo);
    end else begin
      n[0] = a * 32768;
      n[1] = -a * 16384 + b * 28378;
      n[2] = -a * 16384 - b * 28378;
      nmin = n[0];
      nmax = n[0];
      for (int i = 1; i < 3; i++) begin
        if (n[i] < nmin) nmin = n[i];
        if (n[i] > nmax) nmax = n[i];
      end
      for (int i = 0; i < 3; i++)
        d[i] = clamp_pulse(16384 + floor_quot(2 * n[i] - nmin - nmax + vdc, 2 * vdc));
    end
    r.trig_u = TRIG_W'(d[0] >> 1);
    r.trig_v = TRIG_W'(d[1] >> 1);
    // Overmodulation rescales by limit over the largest duty, rounding half up.
    lim = ovm_lim;
    if (!r.bus_fault && ovm_on != 0 && (d[0] > lim || d[1] > lim || d[2] > lim)) begin
      m = d[0];
      if (d[1] > m) m = d[1];
      if (d[2] > m) m = d[2];
      for (int i = 0; i < 3; i++) d[i] = (d[i] * lim + m / 2) / m;
      r.ovm_applied = 1'b1;
    end
    r.duty_a = DUTY_W'(d[0]);
    r.duty_b = DUTY_W'(d[1]);
    r.duty_c = DUTY_W'(d[2]);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Output side: check each transfer and stall at random.
  always @(posedge clk) begin
    duty_set_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          errors++;
          $display("[%0t] result with nothing expected", $time);
        end else begin
          want = expected_duties.pop_front();
          n_checked++;
          if (dut_out.duty_a !== want.duty_a) report_mismatch("duty_a", dut_out.duty_a, want.duty_a);
          if (dut_out.duty_b !== want.duty_b) report_mismatch("duty_b", dut_out.duty_b, want.duty_b);
          if (dut_out.duty_c !== want.duty_c) report_mismatch("duty_c", dut_out.duty_c, want.duty_c);
          if (dut_out.trig_u !== want.trig_u) report_mismatch("trig_u", dut_out.trig_u, want.trig_u);
          if (dut_out.trig_v !== want.trig_v) report_mismatch("trig_v", dut_out.trig_v, want.trig_v);
          if (dut_out.ovm_applied !== want.ovm_applied)
            report_mismatch("ovm_applied", dut_out.ovm_applied, want.ovm_applied);
          if (dut_out.bus_fault !== want.bus_fault)
            report_mismatch("bus_fault", dut_out.bus_fault, want.bus_fault);
        end
        rdy_wait = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (rdy_wait > 0) begin
        rdy_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= DUTY_W'(value);
    case (idx)
      REG_MIN_PULSE:  pulse_lo = value & 16'hFFFF;
      REG_MAX_PULSE:  pulse_hi = value & 16'hFFFF;
      REG_OVM_ENABLE: ovm_on = value & 1;
      REG_OVM_LIMIT:  ovm_lim = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_registers(int unsigned lo, int unsigned hi, int unsigned en,
                               int unsigned lim);
    write_reg(REG_MIN_PULSE, lo);
    write_reg(REG_MAX_PULSE, hi);
    write_reg(REG_OVM_ENABLE, en);
    write_reg(REG_OVM_LIMIT, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends one item, starting at a rising edge; the expectation is queued at
  // the transfer, and the task returns at the transfer edge.
  task automatic send_item(vector_t v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    v_alpha <= v.alpha;
    v_beta <= v.beta;
    dc_bus <= v.bus;
    do @(posedge clk); while (!in_ready);
    expected_duties.push_back(v.typed ? v.result : predict_duties(v.alpha, v.beta, v.bus));
    n_sent++;
    if (v.bus == 0) n_faults++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] edge_volt();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic vector_t random_item();
    vector_t v;
    int kind;
    kind = $urandom_range(0, 9);
    v.typed = 1'b0;
    v.result = '0;
    v.alpha = (kind == 2) ? edge_volt() : VW'($urandom_range(0, 65535));
    v.beta = (kind == 2 || kind == 3) ? edge_volt() : VW'($urandom_range(0, 65535));
    case (kind)
      0: v.bus = '0;
      1: v.bus = VW'($urandom_range(1, 16));
      4, 5: v.bus = VW'($urandom_range(16384, 65535));
      default: v.bus = VW'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // Directed rows; typed results only where they follow at a glance.
  vector_t directed[$];
  vector_t row;
  int unsigned phase_cfg[NUM_PHASES][4] = '{
    '{0, 32768, 0, 32768},
    '{0, 32768, 1, 32768},
    '{1000, 31000, 1, 30000},
    '{20000, 10000, 0, 32768},
    '{0, 32768, 1, 0},
    '{32768, 32768, 1, 1},
    '{0, 0, 0, 32768},
    '{0, 0, 0, 0}
  };

  initial begin
    directed = '{
      '{16'sd0, 16'sd0, 16'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 15'd0, 15'd0, 1'b0, 1'b1}},
      '{16'sd0, 16'sd0, 16'd1, 1'b1,
        '{16'd16384, 16'd16384, 16'd16384, 15'd8192, 15'd8192, 1'b0, 1'b0}},
      '{16'sd0, 16'sd0, 16'hFFFF, 1'b1,
        '{16'd16384, 16'd16384, 16'd16384, 15'd8192, 15'd8192, 1'b0, 1'b0}},
      '{16'sh7FFF, 16'sd0, 16'd1, 1'b1,
        '{16'd32768, 16'd0, 16'd0, 15'd16384, 15'd0, 1'b0, 1'b0}},
      '{16'sh8000, 16'sd0, 16'd1, 1'b1,
        '{16'd0, 16'd32768, 16'd32768, 15'd0, 15'd16384, 1'b0, 1'b0}},
      '{16'sd0, 16'sh7FFF, 16'd1, 1'b0, '0},
      '{16'sd0, 16'sh8000, 16'd1, 1'b0, '0},
      '{16'sh8000, 16'sh8000, 16'hFFFF, 1'b0, '0},
      '{16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0, '0},
      '{-16'sd1, -16'sd1, 16'hFFFF, 1'b0, '0},
      '{16'sd1, 16'sd1, 16'd2, 1'b0, '0},
      '{16'sd10000, -16'sd5000, 16'd20000, 1'b0, '0},
      '{-16'sd12345, 16'sd23456, 16'd40000, 1'b0, '0},
      '{16'sh5555, 16'shAAAA, 16'h5555, 1'b0, '0},
      '{16'shAAAA, 16'sh5555, 16'hAAAA, 1'b0, '0}
    };
    pulse_lo = 0;
    pulse_hi = 32768;
    ovm_on = 0;
    ovm_lim = 32768;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);
    drain();

    // Each phase loads a register setting while the pipeline is empty.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1)
        set_registers($urandom_range(0, 32768), $urandom_range(0, 32768),
                      $urandom_range(0, 1), $urandom_range(1, 32768));
      else
        set_registers(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      no_idle = (p == 2 || p == 5);
      // Phases 3 and 5, two clamp-extreme settings, also repeat the directed rows through the predictor.
      if (p == 3 || p == 5) begin
        foreach (directed[i]) begin
          row = directed[i];
          row.typed = 1'b0;
          send_item(row);
        end
      end
      repeat (RAND_PER_PH) send_item(random_item());
      drain();
    end

    $display("Sent %0d items over %0d register settings, %0d with a zero bus.",
             n_sent, NUM_PHASES + 1, n_faults);
    $display("Checked %0d results, %0d mismatches.", n_checked, errors);
    if (errors == 0 && expected_duties.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/svpwm_pkg.sv
sv/svpwm_div_pipe.sv
sv/svpwm_duty_calculator.sv
verif/svpwm_duty_calculator_test.sv
